// ===== hw/rtl/adaptive_unsharp_pixel_core_macros.svh =====
// Assertion macros for the adaptive unsharp pixel core.
// Expects clk and arst_n to be visible at the place of use.
`ifndef ADAPTIVE_UNSHARP_PIXEL_CORE_MACROS_SVH
`define ADAPTIVE_UNSHARP_PIXEL_CORE_MACROS_SVH

// Plain property, checked on every clock outside reset.
`define AUP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication, checked on every clock outside reset.
`define AUP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/aup_pkg.sv =====
// Shared types and constants of the adaptive unsharp pixel core.
// No dependencies.
package aup_pkg;

	// Item kinds on the input channel.
	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_TABLE = 1'b1
	} req_type_t;

	localparam int NBR_COUNT = 8;   // diamond neighbours per window
	localparam int AVG_SHIFT = 3;   // log2 of NBR_COUNT
	localparam int GAIN_BITS = 16;  // width of one gain table entry
	localparam int COEF_BITS = 18;  // gain plus unity, signed

endpackage

// ===== hw/rtl/aup_window.sv =====
// Input stage: neighbour average, registered window, and activity index.
// Depends on aup_pkg.
module aup_window import aup_pkg::*; #(
	parameter int PIXEL_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          in_valid,
	input  logic                          req_type,
	input  logic [PIXEL_BITS-1:0]         center_pixel,
	input  logic [PIXEL_BITS-1:0]         nbr [NBR_COUNT],
	input  logic [PIXEL_BITS-1:0]         table_index,
	input  logic signed [GAIN_BITS-1:0]   table_value,
	output logic                          valid_s1,
	output req_type_t                     type_s1,
	output logic [PIXEL_BITS-1:0]         x_s1,
	output logic [PIXEL_BITS-1:0]         avg_s1,
	output logic [PIXEL_BITS-1:0]         index_s1,
	output logic signed [GAIN_BITS-1:0]   value_s1,
	output logic [PIXEL_BITS-1:0]         activity
);

	localparam int SUM_BITS = PIXEL_BITS + AVG_SHIFT;
	localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

	logic [SUM_BITS-1:0]   nbr_sum;
	logic [PIXEL_BITS-1:0] nbr_s1 [NBR_COUNT];
	logic [SUM_BITS-1:0]   dev_sum;
	logic [PIXEL_BITS-1:0] dev;

	always_comb begin
		nbr_sum = '0;
		for (int i = 0; i < NBR_COUNT; i++) begin
			nbr_sum = nbr_sum + SUM_BITS'(nbr[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			type_s1  <= req_type_t'(req_type);
			x_s1     <= center_pixel;
			avg_s1   <= nbr_sum[SUM_BITS-1:AVG_SHIFT];
			index_s1 <= table_index;
			value_s1 <= table_value;
			for (int i = 0; i < NBR_COUNT; i++) begin
				nbr_s1[i] <= nbr[i];
			end
		end
	end

	// Sum of absolute deviations, saturated so it always addresses the table.
	always_comb begin
		dev_sum = '0;
		for (int i = 0; i < NBR_COUNT; i++) begin
			dev = (nbr_s1[i] >= avg_s1) ? (nbr_s1[i] - avg_s1) : (avg_s1 - nbr_s1[i]);
			dev_sum = dev_sum + SUM_BITS'(dev);
		end
		activity = (|dev_sum[SUM_BITS-1:PIXEL_BITS]) ? PIX_MAX : dev_sum[PIXEL_BITS-1:0];
	end

endmodule

// ===== hw/rtl/aup_gain_mem.sv =====
// Gain table: one write port, one read port with registered data.
// Depends on aup_pkg.
module aup_gain_mem import aup_pkg::*; #(
	parameter int ADDR_BITS = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_BITS-1:0]        waddr,
	input  logic signed [GAIN_BITS-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_BITS-1:0]        raddr,
	output logic signed [GAIN_BITS-1:0] rdata_q
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic signed [GAIN_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/aup_blend.sv =====
// Blend stages: gain products, clamp and output register.
// Depends on aup_pkg.
module aup_blend import aup_pkg::*; #(
	parameter int PIXEL_BITS    = 10,
	parameter int FRACTION_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s2,
	input  logic signed [GAIN_BITS-1:0] gain_s2,
	input  logic [PIXEL_BITS-1:0]       x_s2,
	input  logic [PIXEL_BITS-1:0]       avg_s2,
	output logic                        ready,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [PIXEL_BITS-1:0]       out_pixel
);

	localparam int PROD_BITS = PIXEL_BITS + 1 + COEF_BITS;
	localparam int DIFF_BITS = PROD_BITS + 1;
	localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << FRACTION_BITS;
	localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

	logic                        valid_s3;
	logic signed [PROD_BITS-1:0] pa_s3;
	logic signed [PROD_BITS-1:0] pb_s3;
	logic                        out_ready;
	logic signed [PIXEL_BITS:0]  xs;
	logic signed [PIXEL_BITS:0]  avs;
	logic signed [COEF_BITS-1:0] coef;
	logic signed [DIFF_BITS-1:0] diff;
	logic [DIFF_BITS-1:0]        shifted;
	logic [PIXEL_BITS-1:0]       result;

	assign out_ready = !out_valid || !out_stall;
	assign ready     = !valid_s3 || out_ready;

	assign xs   = $signed({1'b0, x_s2});
	assign avs  = $signed({1'b0, avg_s2});
	assign coef = COEF_BITS'(gain_s2) + UNITY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s2) begin
			pa_s3 <= PROD_BITS'(xs * coef);
			pb_s3 <= PROD_BITS'(avs * gain_s2);
		end
	end

	// Clamp below at zero, drop the fraction, saturate at the pixel maximum.
	always_comb begin
		diff = DIFF_BITS'(pa_s3) - DIFF_BITS'(pb_s3);
		if (diff < 0) begin
			shifted = '0;
		end else begin
			shifted = DIFF_BITS'(diff) >> FRACTION_BITS;
		end
		result = (|shifted[DIFF_BITS-1:PIXEL_BITS]) ? PIX_MAX : shifted[PIXEL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s3) begin
			out_pixel <= result;
		end
	end

endmodule

// ===== hw/rtl/adaptive_unsharp_pixel_core.sv =====
// Adaptive unsharp pixel core: edge-adaptive luma sharpener with a loadable gain table.
// Path: a pixel item passes the window, gain, product and output registers to out_pixel.
// Throughput: one item per cycle unless stalled; each item reads or writes the gain table once.
// Table writes give no result and take one pipeline slot.
// Reset: arst_n clears all valid flags at once; the gain table is not cleared.
// Depends on aup_pkg, aup_window, aup_gain_mem, aup_blend and the macros header.
module adaptive_unsharp_pixel_core import aup_pkg::*; #(
	parameter int PIXEL_BITS    = 10,
	parameter int FRACTION_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [PIXEL_BITS-1:0]       center_pixel,
	input  logic [PIXEL_BITS-1:0]       up_two,
	input  logic [PIXEL_BITS-1:0]       up_left,
	input  logic [PIXEL_BITS-1:0]       up_right,
	input  logic [PIXEL_BITS-1:0]       left_two,
	input  logic [PIXEL_BITS-1:0]       right_two,
	input  logic [PIXEL_BITS-1:0]       down_left,
	input  logic [PIXEL_BITS-1:0]       down_right,
	input  logic [PIXEL_BITS-1:0]       down_two,
	input  logic [PIXEL_BITS-1:0]       table_index,
	input  logic signed [GAIN_BITS-1:0] table_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [PIXEL_BITS-1:0]       out_pixel
);

	// Stage 1 (window): registered window, activity computed from it.
	logic                        valid_s1;
	req_type_t                   type_s1;
	logic [PIXEL_BITS-1:0]       x_s1;
	logic [PIXEL_BITS-1:0]       avg_s1;
	logic [PIXEL_BITS-1:0]       index_s1;
	logic signed [GAIN_BITS-1:0] value_s1;
	logic [PIXEL_BITS-1:0]       activity;
	logic [PIXEL_BITS-1:0]       nbr [NBR_COUNT];

	// Stage 2: gain read back from the table, with the sample and average.
	logic                        valid_s2;
	logic [PIXEL_BITS-1:0]       x_s2;
	logic [PIXEL_BITS-1:0]       avg_s2;
	logic signed [GAIN_BITS-1:0] gain_s2;

	// Handshake between stages: a stage takes a new item when it is empty
	// or its content moves on in the same cycle.
	logic ready_s1;
	logic ready_s2;
	logic blend_ready;
	logic mem_we;
	logic mem_re;

	assign nbr[0] = up_two;
	assign nbr[1] = up_left;
	assign nbr[2] = up_right;
	assign nbr[3] = left_two;
	assign nbr[4] = right_two;
	assign nbr[5] = down_left;
	assign nbr[6] = down_right;
	assign nbr[7] = down_two;

	assign ready_s2 = !valid_s2 || blend_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// Table accesses happen only as stage 1 hands its item on, so a write
	// always lands before the read of any later pixel: no forwarding needed.
	assign mem_we = ready_s2 && valid_s1 && (type_s1 == REQ_TABLE);
	assign mem_re = ready_s2 && valid_s1 && (type_s1 == REQ_PIXEL);

	aup_window #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (ready_s1),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.center_pixel(center_pixel),
		.nbr         (nbr),
		.table_index (table_index),
		.table_value (table_value),
		.valid_s1    (valid_s1),
		.type_s1     (type_s1),
		.x_s1        (x_s1),
		.avg_s1      (avg_s1),
		.index_s1    (index_s1),
		.value_s1    (value_s1),
		.activity    (activity)
	);

	aup_gain_mem #(
		.ADDR_BITS(PIXEL_BITS)
	) u_gain_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (index_s1),
		.wdata  (value_s1),
		.re     (mem_re),
		.raddr  (activity),
		.rdata_q(gain_s2)
	);

	// Table writes retire here; only pixel items travel on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1 && (type_s1 == REQ_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			x_s2   <= x_s1;
			avg_s2 <= avg_s1;
		end
	end

	aup_blend #(
		.PIXEL_BITS   (PIXEL_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.gain_s2  (gain_s2),
		.x_s2     (x_s2),
		.avg_s2   (avg_s2),
		.ready    (blend_ready),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_pixel(out_pixel)
	);

`include "adaptive_unsharp_pixel_core_macros.svh"

	// The table port never reads and writes in the same cycle.
	`AUP_ASSERT(a_mem_single_access, !(mem_we && mem_re), "gain table read and write collide")
	// A table write leaves no item behind it in stage 2.
	`AUP_ASSERT_IMPL(a_write_no_result, mem_we, ##1 !valid_s2, "table write produced an item")
	// A held stage 2 item keeps its gain.
	`AUP_ASSERT_IMPL(a_gain_hold, valid_s2 && !blend_ready, ##1 $stable(gain_s2), "gain lost on hold")

endmodule
